### rtl/lcb_pkg.sv
`default_nettype none

package lcb_pkg;

    localparam int CELLS_X_DEF = 8;
    localparam int CELLS_Y_DEF = 8;
    localparam int CELLS_Z_DEF = 8;
    localparam int CELL_CAPACITY_DEF = 16;

    // Widest linear cell index over the whole parameter range (64 cells per axis).
    localparam int CELL_W_MAX = 18;

    // Depth of the command queue between front and back; a power of two.
    localparam int Q_DEPTH = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_Z = 3'd5;

    localparam logic [31:0] INV_WIDTH_RESET = 32'h0001_0000;

    localparam logic [2:0] OP_INS_POS  = 3'd0;
    localparam logic [2:0] OP_INS_CELL = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_RESORT   = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    typedef enum logic [2:0] {
        K_RESP,
        K_INSERT,
        K_REMOVE,
        K_CLEAR,
        K_RESORT,
        K_READ
    } t_kind;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [31:0]        tag;
    } t_slot;

    typedef struct packed {
        t_kind                 kind;
        logic [1:0]            status;
        logic [CELL_W_MAX-1:0] cell_idx;
        logic [3:0]            slot;
        t_slot                 data;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/lcb_locate.sv
`default_nettype none

module lcb_locate #(
    parameter int CELLS_X = lcb_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = lcb_pkg::CELLS_Y_DEF,
    parameter int CELLS_Z = lcb_pkg::CELLS_Z_DEF,
    localparam int NUM_CELLS = CELLS_X * CELLS_Y * CELLS_Z,
    localparam int CW = $clog2(NUM_CELLS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic signed [31:0] i_pos [3],
    input  wire logic signed [31:0] i_org [3],
    input  wire logic [31:0]       i_inv [3],
    output logic                   o_valid,
    output logic [CW-1:0]          o_cell,
    output logic                   o_outside
);

    localparam int N_XY  = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
    localparam int N_MAX = (N_XY > CELLS_Z) ? N_XY : CELLS_Z;
    localparam int CO_W  = $clog2(N_MAX);

    logic [3:0]      r_vld;
    logic [CO_W-1:0] r_coord [3];
    logic            r_bad [3];
    logic [CW-1:0]   r_cell;
    logic            r_outside;

    // Four stages: difference, Q32.32 product, range check, linearization.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int NA = (a == 0) ? CELLS_X : ((a == 1) ? CELLS_Y : CELLS_Z);

        logic [32:0] diff;
        logic [31:0] idx;
        logic        ok;
        logic [31:0] r_mag;
        logic [31:0] r_inv;
        logic        r_neg1;
        logic        r_neg2;
        logic        r_invz;
        logic [63:0] r_prod;

        assign diff = {i_pos[a][31], i_pos[a]} - {i_org[a][31], i_org[a]};
        assign idx  = r_prod[63:32];
        // A point below the origin lands in coordinate 0 only when the scale is zero.
        assign ok   = r_neg2 ? r_invz : (idx < 32'(NA));

        always_ff @(posedge i_clk) begin
            r_mag      <= diff[31:0];
            r_neg1     <= diff[32];
            r_inv      <= i_inv[a];
            r_prod     <= 64'(r_mag) * 64'(r_inv);
            r_neg2     <= r_neg1;
            r_invz     <= (r_inv == '0);
            r_coord[a] <= r_neg2 ? '0 : CO_W'(idx);
            r_bad[a]   <= !ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell    <= CW'(r_coord[0]) + CW'(CELLS_X) *
                     (CW'(r_coord[1]) + CW'(CELLS_Y) * CW'(r_coord[2]));
        r_outside <= r_bad[0] | r_bad[1] | r_bad[2];
    end

    assign o_valid   = r_vld[3];
    assign o_cell    = r_cell;
    assign o_outside = r_outside;

endmodule

`default_nettype wire

### rtl/lcb_queue.sv
`default_nettype none

module lcb_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire lcb_pkg::t_cmd i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output lcb_pkg::t_cmd     o_data,
    output logic              o_empty
);

    localparam int AW = $clog2(lcb_pkg::Q_DEPTH);

    lcb_pkg::t_cmd r_mem [lcb_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == (AW+1)'(lcb_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

### rtl/lcb_front.sv
`default_nettype none

module lcb_front #(
    parameter int CELLS_X = lcb_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = lcb_pkg::CELLS_Y_DEF,
    parameter int CELLS_Z = lcb_pkg::CELLS_Z_DEF,
    localparam int NUM_CELLS = CELLS_X * CELLS_Y * CELLS_Z,
    localparam int CW = $clog2(NUM_CELLS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_op,
    input  wire logic [8:0]        i_cell_req,
    input  wire logic [3:0]        i_slot,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic [31:0]       i_tag,
    input  wire logic signed [31:0] i_org [3],
    input  wire logic [31:0]       i_inv [3],
    input  wire logic              i_hold,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output lcb_pkg::t_cmd          o_cmd
);

    logic               r_busy;
    logic [2:0]         r_op;
    logic [8:0]         r_cell_req;
    logic [3:0]         r_slot;
    lcb_pkg::t_slot     r_data;
    logic               accept;
    logic signed [31:0] pos [3];
    logic               loc_valid;
    logic [CW-1:0]      loc_cell;
    logic               loc_outside;
    logic               cell_ok;

    // Only the front pushes, so room seen at the transfer is still there at the push.
    assign o_in_ready = !r_busy && !i_q_full && !i_hold;
    assign accept     = i_in_valid && o_in_ready;

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    lcb_locate #(
        .CELLS_X(CELLS_X),
        .CELLS_Y(CELLS_Y),
        .CELLS_Z(CELLS_Z)
    ) u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pos    (pos),
        .i_org    (i_org),
        .i_inv    (i_inv),
        .o_valid  (loc_valid),
        .o_cell   (loc_cell),
        .o_outside(loc_outside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (loc_valid) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_op;
            r_cell_req <= i_cell_req;
            r_slot     <= i_slot;
            r_data     <= '{px: i_pos_x, py: i_pos_y, pz: i_pos_z, tag: i_tag};
        end
    end

    assign cell_ok = 32'(r_cell_req) < NUM_CELLS;
    assign o_push  = loc_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = lcb_pkg::K_RESP;
        o_cmd.status   = cell_ok ? lcb_pkg::ST_OK : lcb_pkg::ST_ABSENT;
        o_cmd.cell_idx = lcb_pkg::CELL_W_MAX'(r_cell_req);
        o_cmd.slot     = r_slot;
        o_cmd.data     = r_data;
        case (r_op)
            lcb_pkg::OP_INS_POS: begin
                if (loc_outside) begin
                    o_cmd.status   = lcb_pkg::ST_OUTSIDE;
                    o_cmd.cell_idx = '0;
                end else begin
                    o_cmd.kind     = lcb_pkg::K_INSERT;
                    o_cmd.status   = lcb_pkg::ST_OK;
                    o_cmd.cell_idx = lcb_pkg::CELL_W_MAX'(loc_cell);
                end
            end
            lcb_pkg::OP_INS_CELL: o_cmd.kind = cell_ok ? lcb_pkg::K_INSERT : lcb_pkg::K_RESP;
            lcb_pkg::OP_REMOVE:   o_cmd.kind = cell_ok ? lcb_pkg::K_REMOVE : lcb_pkg::K_RESP;
            lcb_pkg::OP_CLEAR:    o_cmd.kind = cell_ok ? lcb_pkg::K_CLEAR : lcb_pkg::K_RESP;
            lcb_pkg::OP_RESORT:   o_cmd.kind = cell_ok ? lcb_pkg::K_RESORT : lcb_pkg::K_RESP;
            lcb_pkg::OP_READ:     o_cmd.kind = cell_ok ? lcb_pkg::K_READ : lcb_pkg::K_RESP;
            default: begin
                o_cmd.status   = lcb_pkg::ST_ABSENT;
                o_cmd.cell_idx = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/lcb_back.sv
`default_nettype none

module lcb_back #(
    parameter int CELLS_X = lcb_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = lcb_pkg::CELLS_Y_DEF,
    parameter int CELLS_Z = lcb_pkg::CELLS_Z_DEF,
    parameter int CELL_CAPACITY = lcb_pkg::CELL_CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic signed [31:0] i_org [3],
    input  wire logic [31:0]       i_inv [3],
    input  wire logic              i_q_empty,
    input  wire lcb_pkg::t_cmd     i_q_data,
    output logic                   o_pop,
    output logic                   o_init_busy,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic [8:0]             o_cell_out,
    output logic [4:0]             o_count,
    output logic signed [31:0]     o_read_x,
    output logic signed [31:0]     o_read_y,
    output logic signed [31:0]     o_read_z,
    output logic [31:0]            o_read_tag
);

    localparam int NUM_CELLS = CELLS_X * CELLS_Y * CELLS_Z;
    localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
    localparam int CW        = $clog2(NUM_CELLS);
    localparam int SW        = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);
    localparam int IDX_W     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CNT,
        S_REMOVE,
        S_READ,
        S_R1_RD,
        S_R1_LOC,
        S_R1_WAIT,
        S_R1_CHK,
        S_R2_RD,
        S_R2_LOC,
        S_R2_WAIT,
        S_R2_APP,
        S_R2_MOVE,
        S_EMIT
    } t_state;

    function automatic logic [SW-1:0] slot_addr(input logic [CW-1:0] c,
                                                input logic [CNT_W-1:0] k);
        return SW'(c) * SW'(CELL_CAPACITY) + SW'(k);
    endfunction

    // Memories
    logic [CNT_W-1:0] r_cnt_mem [NUM_CELLS];
    lcb_pkg::t_slot   r_slot_mem [NUM_SLOTS];
    logic [CNT_W-1:0] r_cnt_rd;
    lcb_pkg::t_slot   r_slot_rd;

    logic             cnt_re;
    logic [CW-1:0]    cnt_raddr;
    logic             cnt_we;
    logic [CW-1:0]    cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic             slot_re;
    logic [SW-1:0]    slot_raddr;
    logic             slot_we;
    logic [SW-1:0]    slot_waddr;
    lcb_pkg::t_slot   slot_wdata;

    // Control and staging registers
    t_state           r_state, n_state;
    lcb_pkg::t_cmd    r_cmd, n_cmd;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_err1, n_err1;
    logic [CW-1:0]    r_t, n_t;
    lcb_pkg::t_slot   r_sd, n_sd;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CW-1:0]    r_tgt [CELL_CAPACITY];
    logic             tgt_we;
    logic [CW-1:0]    r_clr_addr, n_clr_addr;
    logic [1:0]       r_res_status, n_res_status;
    logic [8:0]       r_res_cell, n_res_cell;
    logic [CNT_W-1:0] r_res_count, n_res_count;
    lcb_pkg::t_slot   r_res_data, n_res_data;

    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status;
    logic [8:0]       r_cell_out;
    logic [4:0]       r_count;
    lcb_pkg::t_slot   r_read;
    logic             out_load;

    logic               loc_in_valid;
    logic signed [31:0] loc_pos [3];
    logic               loc_valid;
    logic [CW-1:0]      loc_cell;
    logic               loc_outside;

    logic [CELL_CAPACITY-1:0] match;
    logic [CW-1:0]            cmd_cell;
    logic                     slot_ok;

    assign loc_pos[0] = r_slot_rd.px;
    assign loc_pos[1] = r_slot_rd.py;
    assign loc_pos[2] = r_slot_rd.pz;

    lcb_locate #(
        .CELLS_X(CELLS_X),
        .CELLS_Y(CELLS_Y),
        .CELLS_Z(CELLS_Z)
    ) u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (loc_in_valid),
        .i_pos    (loc_pos),
        .i_org    (i_org),
        .i_inv    (i_inv),
        .o_valid  (loc_valid),
        .o_cell   (loc_cell),
        .o_outside(loc_outside)
    );

    assign cmd_cell = CW'(r_cmd.cell_idx);
    assign slot_ok  = 32'(r_cmd.slot) < 32'(r_cnt_rd);

    // Earlier slots of this cell that head for the same target.
    always_comb begin
        for (int j = 0; j < CELL_CAPACITY; j++) begin
            match[j] = (CNT_W'(j) < r_i) && (r_tgt[j] == loc_cell);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_n          = r_n;
        n_i          = r_i;
        n_err1       = r_err1;
        n_t          = r_t;
        n_sd         = r_sd;
        n_occ        = r_occ;
        n_clr_addr   = r_clr_addr;
        n_res_status = r_res_status;
        n_res_cell   = r_res_cell;
        n_res_count  = r_res_count;
        n_res_data   = r_res_data;
        tgt_we       = 1'b0;
        o_pop        = 1'b0;
        cnt_re       = 1'b0;
        cnt_raddr    = cmd_cell;
        cnt_we       = 1'b0;
        cnt_waddr    = cmd_cell;
        cnt_wdata    = '0;
        slot_re      = 1'b0;
        slot_raddr   = slot_addr(cmd_cell, r_i);
        slot_we      = 1'b0;
        slot_waddr   = slot_addr(cmd_cell, r_i);
        slot_wdata   = r_slot_rd;
        loc_in_valid = 1'b0;
        out_load     = 1'b0;

        case (r_state)
            S_INIT: begin
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CW'(NUM_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_q_data;
                    cnt_re       = 1'b1;
                    cnt_raddr    = CW'(i_q_data.cell_idx);
                    n_res_data   = '0;
                    n_res_status = i_q_data.status;
                    n_res_cell   = 9'(i_q_data.cell_idx);
                    n_res_count  = '0;
                    n_state      = (i_q_data.kind == lcb_pkg::K_RESP) ? S_EMIT : S_CNT;
                end
            end
            S_CNT: begin
                n_n         = r_cnt_rd;
                n_res_count = r_cnt_rd;
                n_state     = S_EMIT;
                case (r_cmd.kind)
                    lcb_pkg::K_INSERT: begin
                        if (32'(r_cnt_rd) >= CELL_CAPACITY) begin
                            n_res_status = lcb_pkg::ST_FULL;
                        end else begin
                            slot_we     = 1'b1;
                            slot_waddr  = slot_addr(cmd_cell, r_cnt_rd);
                            slot_wdata  = r_cmd.data;
                            cnt_we      = 1'b1;
                            cnt_wdata   = r_cnt_rd + CNT_W'(1);
                            n_res_count = r_cnt_rd + CNT_W'(1);
                        end
                    end
                    lcb_pkg::K_REMOVE: begin
                        if (!slot_ok) begin
                            n_res_status = lcb_pkg::ST_ABSENT;
                        end else begin
                            slot_re    = 1'b1;
                            slot_raddr = slot_addr(cmd_cell, r_cnt_rd - CNT_W'(1));
                            n_state    = S_REMOVE;
                        end
                    end
                    lcb_pkg::K_CLEAR: begin
                        cnt_we      = 1'b1;
                        n_res_count = '0;
                    end
                    lcb_pkg::K_READ: begin
                        if (!slot_ok) begin
                            n_res_status = lcb_pkg::ST_ABSENT;
                        end else begin
                            slot_re    = 1'b1;
                            slot_raddr = slot_addr(cmd_cell, CNT_W'(r_cmd.slot));
                            n_state    = S_READ;
                        end
                    end
                    lcb_pkg::K_RESORT: begin
                        n_i     = '0;
                        n_err1  = 1'b0;
                        n_state = S_R1_RD;
                    end
                    default: begin
                        n_res_status = lcb_pkg::ST_ABSENT;
                        n_res_count  = '0;
                    end
                endcase
            end
            S_REMOVE: begin
                slot_we     = 1'b1;
                slot_waddr  = slot_addr(cmd_cell, CNT_W'(r_cmd.slot));
                cnt_we      = 1'b1;
                cnt_wdata   = r_n - CNT_W'(1);
                n_res_count = r_n - CNT_W'(1);
                n_state     = S_EMIT;
            end
            S_READ: begin
                n_res_data = r_slot_rd;
                n_state    = S_EMIT;
            end
            // First pass: slots are located; a leaver's target is checked for room.
            S_R1_RD: begin
                if (r_i < r_n) begin
                    slot_re = 1'b1;
                    n_state = S_R1_LOC;
                end else if (r_err1) begin
                    n_res_status = lcb_pkg::ST_FULL;
                    n_state      = S_EMIT;
                end else begin
                    n_i     = '0;
                    n_state = S_R2_RD;
                end
            end
            S_R1_LOC: begin
                loc_in_valid = 1'b1;
                n_state      = S_R1_WAIT;
            end
            S_R1_WAIT: begin
                if (loc_valid) begin
                    if (loc_outside) begin
                        n_res_status = lcb_pkg::ST_OUTSIDE;
                        n_state      = S_EMIT;
                    end else begin
                        tgt_we = 1'b1;
                        if (loc_cell == cmd_cell) begin
                            n_i     = r_i + CNT_W'(1);
                            n_state = S_R1_RD;
                        end else begin
                            cnt_re    = 1'b1;
                            cnt_raddr = loc_cell;
                            n_occ     = CNT_W'($countones(match) + 1);
                            n_state   = S_R1_CHK;
                        end
                    end
                end
            end
            S_R1_CHK: begin
                if ((CNT_W+1)'(r_cnt_rd) + (CNT_W+1)'(r_occ) > (CNT_W+1)'(CELL_CAPACITY)) begin
                    n_err1 = 1'b1;
                end
                n_i     = r_i + CNT_W'(1);
                n_state = S_R1_RD;
            end
            // Second pass: leavers are appended to their target and the last slot fills the hole.
            S_R2_RD: begin
                if (r_i < r_n) begin
                    slot_re = 1'b1;
                    n_state = S_R2_LOC;
                end else begin
                    cnt_we      = 1'b1;
                    cnt_wdata   = r_n;
                    n_res_count = r_n;
                    n_state     = S_EMIT;
                end
            end
            S_R2_LOC: begin
                loc_in_valid = 1'b1;
                n_sd         = r_slot_rd;
                n_state      = S_R2_WAIT;
            end
            S_R2_WAIT: begin
                if (loc_valid) begin
                    if (loc_cell == cmd_cell) begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_R2_RD;
                    end else begin
                        n_t       = loc_cell;
                        cnt_re    = 1'b1;
                        cnt_raddr = loc_cell;
                        n_state   = S_R2_APP;
                    end
                end
            end
            S_R2_APP: begin
                slot_we    = 1'b1;
                slot_waddr = slot_addr(r_t, r_cnt_rd);
                slot_wdata = r_sd;
                cnt_we     = 1'b1;
                cnt_waddr  = r_t;
                cnt_wdata  = r_cnt_rd + CNT_W'(1);
                slot_re    = 1'b1;
                slot_raddr = slot_addr(cmd_cell, r_n - CNT_W'(1));
                n_state    = S_R2_MOVE;
            end
            S_R2_MOVE: begin
                slot_we = 1'b1;
                n_n     = r_n - CNT_W'(1);
                n_state = S_R2_RD;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_n          <= n_n;
        r_i          <= n_i;
        r_err1       <= n_err1;
        r_t          <= n_t;
        r_sd         <= n_sd;
        r_occ        <= n_occ;
        r_res_status <= n_res_status;
        r_res_cell   <= n_res_cell;
        r_res_count  <= n_res_count;
        r_res_data   <= n_res_data;
        if (tgt_we) begin
            r_tgt[r_i[IDX_W-1:0]] <= loc_cell;
        end
        if (out_load) begin
            r_status   <= r_res_status;
            r_cell_out <= r_res_cell;
            r_count    <= 5'(r_res_count);
            r_read     <= r_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= r_cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_rd <= r_slot_mem[slot_raddr];
        end
    end

    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_cell_out  = r_cell_out;
    assign o_count     = r_count;
    assign o_read_x    = r_read.px;
    assign o_read_y    = r_read.py;
    assign o_read_z    = r_read.pz;
    assign o_read_tag  = r_read.tag;

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop)
        else $error("command taken during count clearing");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (32'(cnt_wdata) <= CELL_CAPACITY))
        else $error("cell count written above capacity");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R2_APP) |-> (32'(r_cnt_rd) < CELL_CAPACITY))
        else $error("resort appends into a full cell");

endmodule

`default_nettype wire

### rtl/linked_cell_particle_binning_top.sv
// The front takes no new item until the previous one has left its four-stage cell locator;
// a resort holds the back while it checks its slots and, if all fit, keeps or moves them.
// Reset is synchronous; afterwards a clearing pass zeroes the cell counts, one cell a cycle,
// and no item is taken until it ends.
`default_nettype none

module linked_cell_particle_binning_top #(
    parameter int CELLS_X = lcb_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = lcb_pkg::CELLS_Y_DEF,
    parameter int CELLS_Z = lcb_pkg::CELLS_Z_DEF,
    parameter int CELL_CAPACITY = lcb_pkg::CELL_CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_op,
    input  wire logic [8:0]                    i_cell_req,
    input  wire logic [3:0]                    i_slot,
    input  wire logic signed [31:0]            i_pos_x,
    input  wire logic signed [31:0]            i_pos_y,
    input  wire logic signed [31:0]            i_pos_z,
    input  wire logic [31:0]                   i_tag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [8:0]                         o_cell_out,
    output logic [4:0]                         o_count,
    output logic signed [31:0]                 o_read_x,
    output logic signed [31:0]                 o_read_y,
    output logic signed [31:0]                 o_read_z,
    output logic [31:0]                        o_read_tag
);

    logic signed [31:0] r_org [3];
    logic [31:0]        r_inv [3];
    logic               q_push;
    lcb_pkg::t_cmd      q_in;
    logic               q_full;
    logic               q_pop;
    lcb_pkg::t_cmd      q_out;
    logic               q_empty;
    logic               init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_inv[0] <= lcb_pkg::INV_WIDTH_RESET;
            r_inv[1] <= lcb_pkg::INV_WIDTH_RESET;
            r_inv[2] <= lcb_pkg::INV_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcb_pkg::CFG_ORIGIN_X:    r_org[0] <= i_cfg_data;
                lcb_pkg::CFG_ORIGIN_Y:    r_org[1] <= i_cfg_data;
                lcb_pkg::CFG_ORIGIN_Z:    r_org[2] <= i_cfg_data;
                lcb_pkg::CFG_INV_WIDTH_X: r_inv[0] <= i_cfg_data;
                lcb_pkg::CFG_INV_WIDTH_Y: r_inv[1] <= i_cfg_data;
                lcb_pkg::CFG_INV_WIDTH_Z: r_inv[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcb_front #(
        .CELLS_X(CELLS_X),
        .CELLS_Y(CELLS_Y),
        .CELLS_Z(CELLS_Z)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_op      (i_op),
        .i_cell_req(i_cell_req),
        .i_slot    (i_slot),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_tag     (i_tag),
        .i_org     (r_org),
        .i_inv     (r_inv),
        .i_hold    (init_busy),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    lcb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    lcb_back #(
        .CELLS_X      (CELLS_X),
        .CELLS_Y      (CELLS_Y),
        .CELLS_Z      (CELLS_Z),
        .CELL_CAPACITY(CELL_CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_org      (r_org),
        .i_inv      (r_inv),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_pop      (q_pop),
        .o_init_busy(init_busy),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_status   (o_status),
        .o_cell_out (o_cell_out),
        .o_count    (o_count),
        .o_read_x   (o_read_x),
        .o_read_y   (o_read_y),
        .o_read_z   (o_read_z),
        .o_read_tag (o_read_tag)
    );

endmodule

`default_nettype wire

### tb/tb_linked_cell_particle_binning_top.sv
`default_nettype none

module tb_linked_cell_particle_binning_top;

    localparam int NX = 8;
    localparam int NY = 8;
    localparam int NZ = 8;
    localparam int CAP = 16;
    localparam int NCELLS = NX * NY * NZ;

    typedef struct {
        logic [2:0]  op;
        logic [8:0]  cell_idx;
        logic [3:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] tag;
    } t_item;

    typedef struct {
        logic [1:0]  status;
        logic [8:0]  cell_idx;
        logic [4:0]  count;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] rtag;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [8:0]  i_cell_req;
    logic [3:0]  i_slot;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic [31:0] i_tag;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [8:0]  o_cell_out;
    logic [4:0]  o_count;
    logic signed [31:0] o_read_x;
    logic signed [31:0] o_read_y;
    logic signed [31:0] o_read_z;
    logic [31:0] o_read_tag;

    linked_cell_particle_binning_top dut (.*);

    // Binning model state.
    logic [31:0] org[3];
    logic [31:0] inv[3];
    int          occupancy[NCELLS];
    logic [31:0] mem_x[NCELLS*CAP];
    logic [31:0] mem_y[NCELLS*CAP];
    logic [31:0] mem_z[NCELLS*CAP];
    logic [31:0] mem_tag[NCELLS*CAP];

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_moved = 0;
    bit      hold_sender = 0;
    bit      long_stall = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_left = 0;

    function automatic int axis_index(logic [31:0] p, logic [31:0] o, logic [31:0] w, int n);
        longint d;
        logic [63:0] prod;
        d = longint'($signed(p)) - longint'($signed(o));
        if (d < 0) return (w == 0) ? 0 : -1;
        prod = 64'(d) * 64'(w);
        if (prod[63:32] >= 32'(n)) return -1;
        return int'(prod[63:32]);
    endfunction

    function automatic int locate(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int cx, cy, cz;
        cx = axis_index(px, org[0], inv[0], NX);
        cy = axis_index(py, org[1], inv[1], NY);
        cz = axis_index(pz, org[2], inv[2], NZ);
        if (cx < 0 || cy < 0 || cz < 0) return -1;
        return cx + NX * (cy + NY * cz);
    endfunction

    function automatic void move_slot(int dst, int src);
        mem_x[dst] = mem_x[src];
        mem_y[dst] = mem_y[src];
        mem_z[dst] = mem_z[src];
        mem_tag[dst] = mem_tag[src];
    endfunction

    function automatic t_result mk(logic [1:0] st, int c, int n);
        t_result r;
        r.status = st;
        r.cell_idx = 9'(c);
        r.count = 5'(n);
        r.rx = '0;
        r.ry = '0;
        r.rz = '0;
        r.rtag = '0;
        return r;
    endfunction

    function automatic t_result bin_insert(int c, t_item it);
        int n, a;
        n = occupancy[c];
        if (n >= CAP) return mk(lcb_pkg::ST_FULL, c, n);
        a = c * CAP + n;
        mem_x[a] = it.px;
        mem_y[a] = it.py;
        mem_z[a] = it.pz;
        mem_tag[a] = it.tag;
        occupancy[c] = n + 1;
        return mk(lcb_pkg::ST_OK, c, n + 1);
    endfunction

    function automatic t_result bin_resort(int c);
        int n, base, i, j, extra, t;
        int dest[CAP];
        n = occupancy[c];
        base = c * CAP;
        for (i = 0; i < n; i++) begin
            dest[i] = locate(mem_x[base+i], mem_y[base+i], mem_z[base+i]);
            if (dest[i] < 0) return mk(lcb_pkg::ST_OUTSIDE, c, n);
        end
        for (i = 0; i < n; i++) begin
            if (dest[i] != c) begin
                extra = 1;
                for (j = 0; j < i; j++)
                    if (dest[j] == dest[i]) extra++;
                if (occupancy[dest[i]] + extra > CAP) return mk(lcb_pkg::ST_FULL, c, n);
            end
        end
        i = 0;
        while (i < n) begin
            t = locate(mem_x[base+i], mem_y[base+i], mem_z[base+i]);
            if (t != c) begin
                move_slot(t * CAP + occupancy[t], base + i);
                occupancy[t]++;
                move_slot(base + i, base + n - 1);
                n--;
                n_moved++;
            end else begin
                i++;
            end
        end
        occupancy[c] = n;
        return mk(lcb_pkg::ST_OK, c, n);
    endfunction

    function automatic t_result bin_step(t_item it);
        int c, n, base, s;
        t_result r;
        if (it.op == lcb_pkg::OP_INS_POS) begin
            c = locate(it.px, it.py, it.pz);
            if (c < 0) return mk(lcb_pkg::ST_OUTSIDE, 0, 0);
            return bin_insert(c, it);
        end
        if (it.op > lcb_pkg::OP_READ) return mk(lcb_pkg::ST_ABSENT, 0, 0);
        c = int'(it.cell_idx);
        if (c >= NCELLS) return mk(lcb_pkg::ST_ABSENT, c, 0);
        n = occupancy[c];
        base = c * CAP;
        s = int'(it.slot);
        case (it.op)
            lcb_pkg::OP_INS_CELL: return bin_insert(c, it);
            lcb_pkg::OP_REMOVE: begin
                if (s >= n) return mk(lcb_pkg::ST_ABSENT, c, n);
                move_slot(base + s, base + n - 1);
                occupancy[c] = n - 1;
                return mk(lcb_pkg::ST_OK, c, n - 1);
            end
            lcb_pkg::OP_CLEAR: begin
                occupancy[c] = 0;
                return mk(lcb_pkg::ST_OK, c, 0);
            end
            lcb_pkg::OP_RESORT: return bin_resort(c);
            default: begin
                if (s >= n) return mk(lcb_pkg::ST_ABSENT, c, n);
                r = mk(lcb_pkg::ST_OK, c, n);
                r.rx = mem_x[base+s];
                r.ry = mem_y[base+s];
                r.rz = mem_z[base+s];
                r.rtag = mem_tag[base+s];
                return r;
            end
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: bursts of offered items separated by random gaps. The transferred item has
    // already left the queue, so the head is always the next one to offer.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_results.push_back(bin_step(pending_items.pop_front()));
            n_sent++;
        end
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (hold_sender || pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                i_op <= pending_items[0].op;
                i_cell_req <= pending_items[0].cell_idx;
                i_slot <= pending_items[0].slot;
                i_pos_x <= pending_items[0].px;
                i_pos_y <= pending_items[0].py;
                i_pos_z <= pending_items[0].pz;
                i_tag <= pending_items[0].tag;
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: status %0d cell %0d", o_status, o_cell_out);
                errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_cell_out !== e.cell_idx) begin
                    $error("cell_out: expected %0d actual %0d", e.cell_idx, o_cell_out);
                    errors++;
                end
                if (o_count !== e.count) begin
                    $error("count: expected %0d actual %0d", e.count, o_count);
                    errors++;
                end
                if (o_read_x !== e.rx) begin
                    $error("read_x: expected %h actual %h", e.rx, o_read_x);
                    errors++;
                end
                if (o_read_y !== e.ry) begin
                    $error("read_y: expected %h actual %h", e.ry, o_read_y);
                    errors++;
                end
                if (o_read_z !== e.rz) begin
                    $error("read_z: expected %h actual %h", e.rz, o_read_z);
                    errors++;
                end
                if (o_read_tag !== e.rtag) begin
                    $error("read_tag: expected %h actual %h", e.rtag, o_read_tag);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (long_stall) begin
            stall_left <= 400;
            long_stall <= 1'b0;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0: stall_left <= $urandom_range(1, 15);
                1, 2: i_out_ready <= 1'b0;
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        // Then let the design settle before the next phase.
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lcb_pkg::CFG_ORIGIN_X: org[0] = v;
            lcb_pkg::CFG_ORIGIN_Y: org[1] = v;
            lcb_pkg::CFG_ORIGIN_Z: org[2] = v;
            lcb_pkg::CFG_INV_WIDTH_X: inv[0] = v;
            lcb_pkg::CFG_INV_WIDTH_Y: inv[1] = v;
            lcb_pkg::CFG_INV_WIDTH_Z: inv[2] = v;
            default: ;
        endcase
    endtask

    task automatic add_item(logic [2:0] op, logic [8:0] c, logic [3:0] s,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] tg);
        t_item it;
        it.op = op;
        it.cell_idx = c;
        it.slot = s;
        it.px = px;
        it.py = py;
        it.pz = pz;
        it.tag = tg;
        pending_items.push_back(it);
    endtask

    // A position that falls in the grid for unit-sized cells at the current origin.
    function automatic logic [31:0] in_grid(int axis, int n);
        return org[axis] + 32'($urandom_range(0, n * 65536 - 1));
    endfunction

    function automatic logic [31:0] any_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 9 * 65536)) - 32'h1_0000;
        endcase
    endfunction

    task automatic random_phase(int cnt, int hot);
        int k, c;
        for (k = 0; k < cnt; k++) begin
            c = $urandom_range(0, hot - 1);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                    add_item(lcb_pkg::OP_INS_POS, $urandom, $urandom, in_grid(0, 2),
                             in_grid(1, 2), in_grid(2, 1), $urandom);
                6: add_item(lcb_pkg::OP_INS_POS, $urandom, $urandom, any_pos(), any_pos(),
                            any_pos(), $urandom);
                7, 8: add_item(lcb_pkg::OP_INS_CELL, 9'(c), $urandom,
                               in_grid(0, NX), in_grid(1, NY), in_grid(2, NZ), $urandom);
                9: add_item(lcb_pkg::OP_INS_CELL, 9'(c), $urandom, any_pos(), any_pos(),
                            any_pos(), $urandom);
                10, 11: add_item(lcb_pkg::OP_REMOVE, 9'(c), $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                12: add_item(lcb_pkg::OP_CLEAR, 9'($urandom_range(0, 1) ? c : $urandom),
                             $urandom, $urandom, $urandom, $urandom, $urandom);
                13, 14: add_item(lcb_pkg::OP_RESORT, 9'(c), $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                15, 16, 17: add_item(lcb_pkg::OP_READ, 9'(c), $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
                default: add_item(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        int k;
        org = '{32'd0, 32'd0, 32'd0};
        inv = '{lcb_pkg::INV_WIDTH_RESET, lcb_pkg::INV_WIDTH_RESET, lcb_pkg::INV_WIDTH_RESET};
        for (k = 0; k < NCELLS; k++) occupancy[k] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_op = '0;
        i_cell_req = '0;
        i_slot = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_tag = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation and each error path at reset settings.
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h0007_ffff, 32'h0007_ffff, 32'h0007_ffff, 32'h0);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h0008_0000, 32'h0, 32'h0, 32'h1);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'hffff_ffff, 32'h0, 32'h0, 32'h1);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1);
        add_item(lcb_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_READ, 0, 1, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_READ, 511, 0, 0, 0, 0, 0);
        for (k = 0; k < 17; k++)
            add_item(lcb_pkg::OP_INS_CELL, 9, 0, 32'(k) << 16, 32'h1_0000, 32'h0, 32'(k));
        add_item(lcb_pkg::OP_REMOVE, 9, 15, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_REMOVE, 9, 3, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_READ, 9, 3, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_RESORT, 9, 0, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_READ, 9, 0, 0, 0, 0, 0);
        add_item(lcb_pkg::OP_CLEAR, 9, 0, 0, 0, 0, 0);
        add_item(3'd6, 9'h1ff, 4'hf, 0, 0, 0, 0);
        add_item(3'd7, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // A cell holding particles that now lie elsewhere: resort must refuse or move them.
        write_reg(lcb_pkg::CFG_ORIGIN_X, 32'h8000_0000);
        write_reg(lcb_pkg::CFG_ORIGIN_Y, 32'h7fff_ffff);
        write_reg(lcb_pkg::CFG_ORIGIN_Z, 32'hffff_0000);
        write_reg(lcb_pkg::CFG_INV_WIDTH_X, 32'h0);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Y, 32'hffff_ffff);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Z, 32'h0000_8000);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        add_item(lcb_pkg::OP_INS_POS, 0, 0, 32'h0, 32'h7fff_ffff, 32'hffff_0000, 2);
        add_item(lcb_pkg::OP_RESORT, 0, 0, 0, 0, 0, 0);
        wait_drained();

        write_reg(lcb_pkg::CFG_ORIGIN_X, 32'h0);
        write_reg(lcb_pkg::CFG_ORIGIN_Y, 32'h0);
        write_reg(lcb_pkg::CFG_ORIGIN_Z, 32'h0);
        write_reg(lcb_pkg::CFG_INV_WIDTH_X, lcb_pkg::INV_WIDTH_RESET);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Y, lcb_pkg::INV_WIDTH_RESET);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Z, lcb_pkg::INV_WIDTH_RESET);
        // Fill cell 1 with particles whose positions map to cell 0, then resort.
        for (k = 0; k < 6; k++)
            add_item(lcb_pkg::OP_INS_CELL, 1, 0, 32'h100 * k, 32'h0, 32'h0, 32'(100 + k));
        add_item(lcb_pkg::OP_RESORT, 1, 0, 0, 0, 0, 0);
        random_phase(250, 16);
        // Long receiver hold-off while the sender keeps offering items.
        long_stall = 1'b1;
        wait_drained();

        // Shifted, coarse grid: two unit widths per cell along x, negative origin.
        write_reg(lcb_pkg::CFG_ORIGIN_X, 32'hfffc_0000);
        write_reg(lcb_pkg::CFG_INV_WIDTH_X, 32'h0000_8000);
        random_phase(200, 8);
        wait_drained();

        // Extreme corners of the registers.
        write_reg(lcb_pkg::CFG_ORIGIN_Y, 32'h7fff_ffff);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Y, 32'hffff_ffff);
        write_reg(lcb_pkg::CFG_ORIGIN_Z, 32'h8000_0000);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Z, 32'h0);
        random_phase(80, 64);
        // Partway through, the sender pauses until every outstanding result has come back.
        repeat (300) @(posedge i_clk);
        hold_sender = 1'b1;
        while (i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();

        write_reg(lcb_pkg::CFG_ORIGIN_X, 32'h0);
        write_reg(lcb_pkg::CFG_ORIGIN_Y, 32'h0);
        write_reg(lcb_pkg::CFG_ORIGIN_Z, 32'h0);
        write_reg(lcb_pkg::CFG_INV_WIDTH_X, lcb_pkg::INV_WIDTH_RESET);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Y, lcb_pkg::INV_WIDTH_RESET);
        write_reg(lcb_pkg::CFG_INV_WIDTH_Z, lcb_pkg::INV_WIDTH_RESET);
        random_phase(200, 16);
        wait_drained();

        $display("Run covered %0d operations and %0d checked results; resorts moved %0d particles.",
                 n_sent, n_checked, n_moved);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
